>>> rtl/core/gn2d_pkg.sv
// shared types, codes and constants of the 2d gradient noise block
`default_nettype none

package gn2d_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_GRID_W_DEF    = 64;
  localparam int MAX_GRID_H_DEF    = 64;
  localparam int POS_FRAC_BITS_DEF = 10;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] GRID_W_RESET    = 7'd64;
  localparam logic [CFG_DATA_W-1:0] GRID_H_RESET    = 7'd64;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // width of cell and fraction fields carried in a job
  localparam int CELL_W = 16;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               kind;
    logic [5:0]         corner_col;
    logic [5:0]         corner_row;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               out_of_range;
  } result_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SAMPLE,
    OP_OOR
  } op_t;

  // classified job passed from front to back
  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] frac_x;
    logic [CELL_W-1:0] frac_y;
    logic [15:0]       grad_x;
    logic [15:0]       grad_y;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/gradient_noise_2d.sv
// top level of the 2d gradient noise block
//
// channel  | ports                          | handshake
// ---------+--------------------------------+--------------------------------
// item     | start, busy, item              | beat taken when start & !busy
// config   | cfg_we, cfg_index, cfg_data    | write taken when cfg_we
// result   | done, result                   | beat shown for one cycle on done
//
// one item per cycle while busy is low; a sample beat passes the queue entry,
// the bank read and the pipeline stages, and done rises as its result shows:
// the gradient banks read while the job sits at the queue head, then seven
// stages form products, dots, blends and the rounded, saturated result. the
// four corners sit in four banks split by row and column parity, so each
// sample needs one read per bank. write beats give no result. the back end
// never stalls, so busy only rises if the queue fills. reset clears control
// only; no clearing pass.
`default_nettype none

module gradient_noise_2d #(
  parameter int MAX_GRID_W    = gn2d_pkg::MAX_GRID_W_DEF,
  parameter int MAX_GRID_H    = gn2d_pkg::MAX_GRID_H_DEF,
  parameter int POS_FRAC_BITS = gn2d_pkg::POS_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire gn2d_pkg::in_item_t              item,
  input  wire logic                            cfg_we,
  input  wire logic [gn2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gn2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 done,
  output gn2d_pkg::result_t                    result
);

  logic           push, full, head_valid;
  gn2d_pkg::job_t job, head;

  // accept and classify
  gn2d_front #(
    .MAX_GRID_W    (MAX_GRID_W),
    .MAX_GRID_H    (MAX_GRID_H),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push),
    .job       (job)
  );

  // job queue
  gn2d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job        (job),
    .full       (full),
    .pop        (head_valid),
    .head_valid (head_valid),
    .head       (head)
  );

  // gradient store and noise pipeline
  gn2d_back #(
    .MAX_GRID_W    (MAX_GRID_W),
    .MAX_GRID_H    (MAX_GRID_H),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .done       (done),
    .result     (result)
  );

endmodule

`default_nettype wire

>>> rtl/core/gn2d_front.sv
// front end: config registers, item accept and classification
`default_nettype none

module gn2d_front #(
  parameter int MAX_GRID_W    = gn2d_pkg::MAX_GRID_W_DEF,
  parameter int MAX_GRID_H    = gn2d_pkg::MAX_GRID_H_DEF,
  parameter int POS_FRAC_BITS = gn2d_pkg::POS_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire gn2d_pkg::in_item_t             item,
  output logic                                busy,
  input  wire logic                           cfg_we,
  input  wire logic [gn2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gn2d_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           full,
  output logic                                push,
  output gn2d_pkg::job_t                      job
);

  localparam int F = POS_FRAC_BITS;
  localparam logic [15:0] FRAC_MASK = 16'((17'(1) << F) - 17'(1));
  localparam logic [16:0] LIM_W_MAX = 17'(MAX_GRID_W);
  localparam logic [16:0] LIM_H_MAX = 17'(MAX_GRID_H);

  logic [gn2d_pkg::CFG_DATA_W-1:0] grid_width;
  logic [gn2d_pkg::CFG_DATA_W-1:0] grid_height;

  logic [15:0] x0, y0, sx, sy;
  logic [16:0] lim_w, lim_h;
  logic        oor, in_store, accept, is_sample;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gn2d_pkg::GRID_W_RESET;
      grid_height <= gn2d_pkg::GRID_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gn2d_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        gn2d_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  // cell and fraction of the sample position
  assign x0 = item.pos_x >> F;
  assign y0 = item.pos_y >> F;
  assign sx = item.pos_x & FRAC_MASK;
  assign sy = item.pos_y & FRAC_MASK;

  // grid limits in use
  assign lim_w = (17'(grid_width) < LIM_W_MAX) ? 17'(grid_width) : LIM_W_MAX;
  assign lim_h = (17'(grid_height) < LIM_H_MAX) ? 17'(grid_height) : LIM_H_MAX;

  // cell range check and store range check
  assign oor = ((17'(x0) + 17'd1) >= lim_w) || ((17'(y0) + 17'd1) >= lim_h);
  assign in_store = (17'(item.corner_col) < LIM_W_MAX) &&
                    (17'(item.corner_row) < LIM_H_MAX);

  // accept and push; writes outside the store are dropped here
  assign busy      = full;
  assign accept    = start && !full;
  assign is_sample = (item.kind == gn2d_pkg::KIND_SAMPLE);
  assign push      = accept && (is_sample || in_store);

  // job build
  always_comb begin
    job.grad_x = item.grad_x;
    job.grad_y = item.grad_y;
    if (is_sample) begin
      job.op     = oor ? gn2d_pkg::OP_OOR : gn2d_pkg::OP_SAMPLE;
      job.col    = x0;
      job.row    = y0;
      job.frac_x = sx;
      job.frac_y = sy;
    end else begin
      job.op     = gn2d_pkg::OP_WRITE;
      job.col    = gn2d_pkg::CELL_W'(item.corner_col);
      job.row    = gn2d_pkg::CELL_W'(item.corner_row);
      job.frac_x = '0;
      job.frac_y = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gn2d_queue.sv
// short job queue between front and back
`default_nettype none

module gn2d_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gn2d_pkg::job_t job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output gn2d_pkg::job_t      head
);

  localparam int QD  = gn2d_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

  gn2d_pkg::job_t   entries [QD];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;
  logic             do_pop;

  assign full       = (count == (QAW+1)'(QD));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gn2d_bank.sv
// single port gradient bank with registered read
`default_nettype none

module gn2d_bank #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/gn2d_back.sv
// back end: banked gradient store and noise pipeline
`default_nettype none

module gn2d_back #(
  parameter int MAX_GRID_W    = gn2d_pkg::MAX_GRID_W_DEF,
  parameter int MAX_GRID_H    = gn2d_pkg::MAX_GRID_H_DEF,
  parameter int POS_FRAC_BITS = gn2d_pkg::POS_FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire gn2d_pkg::job_t head,
  output logic                done,
  output gn2d_pkg::result_t   result
);

  localparam int F          = POS_FRAC_BITS;
  localparam int HALF_W     = (MAX_GRID_W + 1) / 2;
  localparam int HALF_H     = (MAX_GRID_H + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int OW  = F + 1;      // corner offset
  localparam int WW  = F + 2;      // blend weight
  localparam int PW  = F + 17;     // offset times gradient
  localparam int DW  = F + 18;     // dot product
  localparam int BPW = DW + WW;    // x blend product
  localparam int BSW = BPW + 1;    // x blend sum
  localparam int IW  = DW + 1;     // blended value
  localparam int YPW = IW + WW;    // y blend product
  localparam int YSW = YPW + 1;    // y blend sum
  localparam int FW  = IW + 1;     // final rounding

  localparam logic [WW-1:0]  ONE_W  = WW'(1) << F;
  localparam logic [BSW-1:0] HALF_B = BSW'(1) << (F - 1);
  localparam logic [YSW-1:0] HALF_Y = YSW'(1) << (F - 1);
  localparam logic [FW-1:0]  HALF_F = FW'(1) << (F - 1);
  localparam logic signed [FW-1:0] SAT_HI = FW'(32767);
  localparam logic signed [FW-1:0] SAT_LO = -FW'(32768);

  logic        is_wr;
  logic [31:0] rd [4];

  // bank access, one corner per bank by row and column parity
  assign is_wr = (head.op == gn2d_pkg::OP_WRITE);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BC = 1'(b % 2);
    localparam logic BR = 1'(b / 2);
    logic [16:0]        csel, rsel;
    logic [31:0]        lin;
    logic [BANK_AW-1:0] addr;
    logic               we;

    assign csel = (is_wr || head.col[0] == BC) ? {1'b0, head.col} : {1'b0, head.col} + 17'd1;
    assign rsel = (is_wr || head.row[0] == BR) ? {1'b0, head.row} : {1'b0, head.row} + 17'd1;
    assign lin  = 32'(rsel[16:1]) * 32'(HALF_W) + 32'(csel[16:1]);
    assign addr = lin[BANK_AW-1:0];
    assign we   = head_valid && is_wr && head.row[0] == BR && head.col[0] == BC;

    gn2d_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .addr  (addr),
      .wdata ({head.grad_y, head.grad_x}),
      .rdata (rd[b])
    );
  end

  // stage control
  logic v1, v2, v3, v4, v5, v6, v7;
  logic o1, o2, o3, o4, o5, o6, o7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= head_valid && !is_wr;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  // stage 1: cell parity and fractions while the banks read
  logic         px1, py1;
  logic [F-1:0] sx1, sy1;

  always_ff @(posedge clk) begin
    o1  <= (head.op == gn2d_pkg::OP_OOR);
    px1 <= head.col[0];
    py1 <= head.row[0];
    sx1 <= head.frac_x[F-1:0];
    sy1 <= head.frac_y[F-1:0];
  end

  // corner gradients and offsets
  logic [31:0]          e00, e10, e01, e11;
  logic signed [OW-1:0] dx0, dx1, dy0, dy1;

  assign e00 = rd[{py1, px1}];
  assign e10 = rd[{py1, ~px1}];
  assign e01 = rd[{~py1, px1}];
  assign e11 = rd[{~py1, ~px1}];
  assign dx0 = $signed({1'b0, sx1});
  assign dx1 = $signed({1'b1, sx1});
  assign dy0 = $signed({1'b0, sy1});
  assign dy1 = $signed({1'b1, sy1});

  // stage 2: offset times gradient
  logic signed [PW-1:0] pa00, pb00, pa10, pb10, pa01, pb01, pa11, pb11;
  logic [F-1:0]         sx2, sy2;

  always_ff @(posedge clk) begin
    o2   <= o1;
    sx2  <= sx1;
    sy2  <= sy1;
    pa00 <= dx0 * $signed(e00[15:0]);
    pb00 <= dy0 * $signed(e00[31:16]);
    pa10 <= dx1 * $signed(e10[15:0]);
    pb10 <= dy0 * $signed(e10[31:16]);
    pa01 <= dx0 * $signed(e01[15:0]);
    pb01 <= dy1 * $signed(e01[31:16]);
    pa11 <= dx1 * $signed(e11[15:0]);
    pb11 <= dy1 * $signed(e11[31:16]);
  end

  // stage 3: dot products
  logic signed [DW-1:0] n00, n10, n01, n11;
  logic [F-1:0]         sx3, sy3;

  always_ff @(posedge clk) begin
    o3  <= o2;
    sx3 <= sx2;
    sy3 <= sy2;
    n00 <= DW'(pa00) + DW'(pb00);
    n10 <= DW'(pa10) + DW'(pb10);
    n01 <= DW'(pa01) + DW'(pb01);
    n11 <= DW'(pa11) + DW'(pb11);
  end

  // stage 4: x blend products
  logic signed [WW-1:0]  w0x, w1x;
  logic signed [BPW-1:0] b00, b10, b01, b11;
  logic [F-1:0]          sy4;

  assign w0x = $signed(ONE_W - {2'b00, sx3});
  assign w1x = $signed({2'b00, sx3});

  always_ff @(posedge clk) begin
    o4  <= o3;
    sy4 <= sy3;
    b00 <= n00 * w0x;
    b10 <= n10 * w1x;
    b01 <= n01 * w0x;
    b11 <= n11 * w1x;
  end

  // stage 5: x blend sums, rounded
  logic signed [IW-1:0] ix0, ix1;
  logic [F-1:0]         sy5;

  always_ff @(posedge clk) begin
    o5  <= o4;
    sy5 <= sy4;
    ix0 <= IW'((BSW'(b00) + BSW'(b10) + $signed(HALF_B)) >>> F);
    ix1 <= IW'((BSW'(b01) + BSW'(b11) + $signed(HALF_B)) >>> F);
  end

  // stage 6: y blend products
  logic signed [WW-1:0]  w0y, w1y;
  logic signed [YPW-1:0] q0, q1;

  assign w0y = $signed(ONE_W - {2'b00, sy5});
  assign w1y = $signed({2'b00, sy5});

  always_ff @(posedge clk) begin
    o6 <= o5;
    q0 <= ix0 * w0y;
    q1 <= ix1 * w1y;
  end

  // stage 7: y blend sum, rounded
  logic signed [IW-1:0] yb;

  always_ff @(posedge clk) begin
    o7 <= o6;
    yb <= IW'((YSW'(q0) + YSW'(q1) + $signed(HALF_Y)) >>> F);
  end

  // final rounding to q2.14 and saturation
  logic signed [FW-1:0] fv;
  logic signed [15:0]   sat;

  assign fv = (FW'(yb) + $signed(HALF_F)) >>> F;

  always_comb begin
    if (fv > SAT_HI) begin
      sat = 16'sh7FFF;
    end else if (fv < SAT_LO) begin
      sat = 16'sh8000;
    end else begin
      sat = fv[15:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    result.noise_value  <= o7 ? 16'sh0000 : sat;
    result.out_of_range <= o7;
  end

endmodule

`default_nettype wire

>>> verif/tb_gradient_noise_2d.sv
// self-checking testbench for the 2d gradient noise block
`timescale 1ns / 1ps

module tb_gradient_noise_2d;

  localparam int     MAX_W        = gn2d_pkg::MAX_GRID_W_DEF;
  localparam int     MAX_H        = gn2d_pkg::MAX_GRID_H_DEF;
  localparam int     FRAC         = gn2d_pkg::POS_FRAC_BITS_DEF;
  localparam int     CELL_SPAN    = 1 << FRAC;
  localparam longint ONE          = longint'(1) << FRAC;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     NUM_ROWS     = 20;
  localparam int     NUM_PHASES   = 9;
  localparam int     DW           = gn2d_pkg::CFG_DATA_W;

  localparam logic K_WR  = gn2d_pkg::KIND_WRITE;
  localparam logic K_SMP = gn2d_pkg::KIND_SAMPLE;

  localparam gn2d_pkg::result_t OOR_RES  = '{noise_value: 16'sd0, out_of_range: 1'b1};
  localparam gn2d_pkg::result_t ZERO_RES = '{noise_value: 16'sd0, out_of_range: 1'b0};

  typedef struct {
    logic              kind;
    logic [5:0]        col;
    logic [5:0]        row;
    logic [15:0]       gx;
    logic [15:0]       gy;
    logic [15:0]       px;
    logic [15:0]       py;
    bit                typed;
    gn2d_pkg::result_t want;
  } stim_row_t;

  typedef struct {
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    int            n;
  } phase_t;

  // directed beats: extreme gradients around the first and last cells,
  // grid points, cell edges and cells past the grid
  stim_row_t stim_table [NUM_ROWS] = '{
    '{K_WR,  6'd0,  6'd0,  16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd1,  6'd0,  16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd0,  6'd1,  16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd1,  6'd1,  16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd62, 6'd62, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd63, 6'd62, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd62, 6'd63, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd63, 6'd63, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'h0200, 16'h0200, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'h03FF, 16'h03FF, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'hFA00, 16'hFA00, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'hFBFF, 16'hFBFF, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'hF800, 16'hF800, 1'b1, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'hFC00, 16'h0000, 1'b1, OOR_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'h0000, 16'hFC00, 1'b1, OOR_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, OOR_RES},
    '{K_WR,  6'd0,  6'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_WR,  6'd5,  6'd9,  16'h4000, 16'hC000, 16'h0000, 16'h0000, 1'b0, ZERO_RES},
    '{K_SMP, 6'd0,  6'd0,  16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b0, ZERO_RES}
  };

  // grid settings for the random part; one entry is replaced at run time
  phase_t phases [NUM_PHASES] = '{
    '{7'd64,  7'd64,  300},
    '{7'd2,   7'd2,   80},
    '{7'd127, 7'd127, 200},
    '{7'd0,   7'd0,   40},
    '{7'd1,   7'd64,  40},
    '{7'd64,  7'd1,   40},
    '{7'd37,  7'd5,   120},
    '{7'd64,  7'd64,  150},
    '{7'd64,  7'd64,  130}
  };

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  gn2d_pkg::in_item_t             item      = '0;
  logic                           cfg_we    = 1'b0;
  logic [gn2d_pkg::CFG_IDX_W-1:0] cfg_index = gn2d_pkg::REG_GRID_WIDTH;
  logic [DW-1:0]                  cfg_data  = '0;
  logic                           busy;
  logic                           done;
  gn2d_pkg::result_t              result;

  // predictor state
  logic [31:0]   grad_mem [MAX_W * MAX_H];
  bit            written  [MAX_W * MAX_H];
  logic [DW-1:0] grid_w_cfg = gn2d_pkg::GRID_W_RESET;
  logic [DW-1:0] grid_h_cfg = gn2d_pkg::GRID_H_RESET;

  gn2d_pkg::result_t noise_q [$];
  int                failures    = 0;
  int                items_sent  = 0;
  int                idle_cycles = 0;
  bit                steady      = 1'b0;

  gradient_noise_2d i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int span_w();
    return (grid_w_cfg < MAX_W) ? int'(grid_w_cfg) : MAX_W;
  endfunction

  function automatic int span_h();
    return (grid_h_cfg < MAX_H) ? int'(grid_h_cfg) : MAX_H;
  endfunction

  // divide by 2^FRAC, nearest, ties upward
  function automatic longint half_up_shift(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint corner_dot(int col, int row, longint dx, longint dy);
    logic [31:0] e;
    e = grad_mem[row * MAX_W + col];
    return dx * longint'($signed(e[15:0])) + dy * longint'($signed(e[31:16]));
  endfunction

  function automatic longint lerp(longint a0, longint a1, longint s);
    return half_up_shift(a0 * (ONE - s) + a1 * s);
  endfunction

  function automatic gn2d_pkg::result_t noise_at(gn2d_pkg::in_item_t it);
    gn2d_pkg::result_t r;
    int      x0;
    int      y0;
    longint  sx;
    longint  sy;
    longint  n00;
    longint  n10;
    longint  n01;
    longint  n11;
    longint  v;
    x0 = int'(it.pos_x >> FRAC);
    y0 = int'(it.pos_y >> FRAC);
    sx = longint'(it.pos_x[FRAC-1:0]);
    sy = longint'(it.pos_y[FRAC-1:0]);
    if (x0 + 1 >= span_w() || y0 + 1 >= span_h()) begin
      return OOR_RES;
    end
    n00 = corner_dot(x0,     y0,     sx,       sy);
    n10 = corner_dot(x0 + 1, y0,     sx - ONE, sy);
    n01 = corner_dot(x0,     y0 + 1, sx,       sy - ONE);
    n11 = corner_dot(x0 + 1, y0 + 1, sx - ONE, sy - ONE);
    v = half_up_shift(lerp(lerp(n00, n10, sx), lerp(n01, n11, sx), sy));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.noise_value  = 16'(v);
    r.out_of_range = 1'b0;
    return r;
  endfunction

  function automatic void store_gradient(gn2d_pkg::in_item_t it);
    int idx;
    if (it.corner_col < MAX_W && it.corner_row < MAX_H) begin
      idx = int'(it.corner_row) * MAX_W + int'(it.corner_col);
      grad_mem[idx] = {it.grad_y, it.grad_x};
      written[idx]  = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 63) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic gn2d_pkg::in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(gn2d_pkg::in_item_t)-1:0];
  endfunction

  // uniform half the time, else one of four fixed values including the extremes
  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] cell_pos(int c);
    int f;
    case ($urandom_range(0, 9))
      0: f = 0;
      1: f = CELL_SPAN - 1;
      default: f = $urandom_range(0, CELL_SPAN - 1);
    endcase
    return 16'(c * CELL_SPAN + f);
  endfunction

  // present one beat, wait for it to be taken, then predict it
  task automatic drive_beat(input gn2d_pkg::in_item_t it, input bit typed,
                            input gn2d_pkg::result_t want);
    int                gap;
    gn2d_pkg::result_t exp_res;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (it.kind == gn2d_pkg::KIND_SAMPLE) begin
      exp_res = typed ? want : noise_at(it);
      noise_q.insert(noise_q.size(), exp_res);
    end else begin
      store_gradient(it);
    end
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_corner(input int col, input int row);
    gn2d_pkg::in_item_t it;
    it            = random_item();
    it.kind       = gn2d_pkg::KIND_WRITE;
    it.corner_col = 6'(col);
    it.corner_row = 6'(row);
    it.grad_x     = rand_grad();
    it.grad_y     = rand_grad();
    drive_beat(it, 1'b0, ZERO_RES);
  endtask

  task automatic send_sample(input logic [15:0] px, input logic [15:0] py);
    gn2d_pkg::in_item_t it;
    it       = random_item();
    it.kind  = gn2d_pkg::KIND_SAMPLE;
    it.pos_x = px;
    it.pos_y = py;
    drive_beat(it, 1'b0, ZERO_RES);
  endtask

  // make sure all four corners of a cell hold a gradient before sampling it
  task automatic ensure_cell(input int x0, input int y0, input bit rewrite);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (rewrite || !written[(y0 + dy) * MAX_W + x0 + dx]) write_corner(x0 + dx, y0 + dy);
      end
    end
  endtask

  // registers change only once the pipeline is empty
  task automatic set_grid(input logic [DW-1:0] w, input logic [DW-1:0] h);
    start <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gn2d_pkg::REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= gn2d_pkg::REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    grid_w_cfg  = w;
    grid_h_cfg  = h;
  endtask

  task automatic run_random(input int count);
    int          stop_at;
    int          pick;
    int          x0;
    int          y0;
    int          k;
    logic [15:0] px;
    logic [15:0] py;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && span_w() >= 2 && span_h() >= 2) begin
        // fill a cell, then sample inside it
        x0 = $urandom_range(0, span_w() - 2);
        y0 = $urandom_range(0, span_h() - 2);
        ensure_cell(x0, y0, 1'($urandom_range(0, 1)));
        k = $urandom_range(1, 4);
        repeat (k) send_sample(cell_pos(x0), cell_pos(y0));
      end else if (pick < 75) begin
        // anywhere in the position space
        px = 16'($urandom);
        py = 16'($urandom);
        x0 = int'(px >> FRAC);
        y0 = int'(py >> FRAC);
        if (x0 + 1 < span_w() && y0 + 1 < span_h()) ensure_cell(x0, y0, 1'b0);
        send_sample(px, py);
      end else if (pick < 90) begin
        write_corner($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        // cell past the right or top edge of the grid in use
        x0 = $urandom_range(0, 63);
        y0 = $urandom_range(0, 63);
        if ($urandom_range(0, 1)) x0 = $urandom_range((span_w() > 0) ? span_w() - 1 : 0, 63);
        else y0 = $urandom_range((span_h() > 0) ? span_h() - 1 : 0, 63);
        send_sample(cell_pos(x0), cell_pos(y0));
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  // result beat against the oldest expectation
  always @(posedge clk) begin
    gn2d_pkg::result_t want;
    if (!rst && done !== 1'b0) begin
      if (noise_q.size() == 0) begin
        $error("unexpected result beat: noise_value %0d out_of_range %0b",
               result.noise_value, result.out_of_range);
        failures++;
      end else begin
        want = noise_q.pop_front();
        if (result.noise_value !== want.noise_value) begin
          $error("noise_value: expected %0d, actual %0d", want.noise_value, result.noise_value);
          failures++;
        end
        if (result.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, actual %0b", want.out_of_range,
                 result.out_of_range);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no beat of any kind
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("gradient_noise_2d regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    gn2d_pkg::in_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset grid size
    foreach (stim_table[i]) begin
      it            = '0;
      it.kind       = stim_table[i].kind;
      it.corner_col = stim_table[i].col;
      it.corner_row = stim_table[i].row;
      it.grad_x     = stim_table[i].gx;
      it.grad_y     = stim_table[i].gy;
      it.pos_x      = stim_table[i].px;
      it.pos_y      = stim_table[i].py;
      drive_beat(it, stim_table[i].typed, stim_table[i].want);
    end

    // random phases over several grid sizes
    phases[7].w = 7'($urandom_range(2, 64));
    phases[7].h = 7'($urandom_range(2, 64));
    foreach (phases[p]) begin
      set_grid(phases[p].w, phases[p].h);
      run_random(phases[p].n);
    end

    start <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && noise_q.size() == 0) begin
      $display("gradient_noise_2d regression: pass");
    end else begin
      $display("gradient_noise_2d regression: fail");
    end
    $finish;
  end

endmodule
